// ----- sv/nll_pkg.sv -----
// Shared types, codes and character helpers for the numeric literal lexer.
package nll_pkg;

  typedef enum logic [2:0] {
    KIND_INT    = 3'd0,
    KIND_BYTE   = 3'd1,
    KIND_SHORT  = 3'd2,
    KIND_LONG   = 3'd3,
    KIND_FLOAT  = 3'd4,
    KIND_DOUBLE = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ERR_OK         = 3'd0,
    ERR_BAD_PREFIX = 3'd1,
    ERR_BAD_LIT    = 3'd2,
    ERR_BAD_SUFFIX = 3'd3,
    ERR_NO_DIGITS  = 3'd4,
    ERR_RANGE      = 3'd5
  } err_t;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_BIN = 2'd2
  } radix_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_Y     = 8'h79;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [63:0] MASK_BYTE  = 64'h0000_0000_0000_00FF;
  localparam logic [63:0] MASK_SHORT = 64'h0000_0000_0000_FFFF;
  localparam logic [63:0] MASK_INT   = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  pos;
    logic        first_zero;
    radix_t      radix;
    logic        dot_seen;
    logic        digit_seen;
    logic [63:0] acc;
    logic        ovf_seen;
    err_t        err;
  } nll_state_t;

  typedef struct packed {
    err_t        err;
    logic [63:0] value;
    kind_t       kind;
  } nll_result_t;

  localparam nll_state_t STATE_RST = '0;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c inside {[CH_UP_A:CH_UP_Z]}) ? c + CASE_OFS : c;
  endfunction

  // Returns {is_digit, digit} for the given radix.
  function automatic logic [4:0] digit_of(input logic [7:0] c, input radix_t r);
    logic [3:0] d;
    logic       ok;
    d  = '0;
    ok = 1'b0;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      d  = 4'(c - CH_ZERO);
      ok = 1'b1;
    end else if (c inside {[CH_LO_A:CH_LO_F]}) begin
      d  = 4'(c - CH_LO_A + 8'd10);
      ok = 1'b1;
    end else if (c inside {[CH_UP_A:CH_UP_F]}) begin
      d  = 4'(c - CH_UP_A + 8'd10);
      ok = 1'b1;
    end
    case (r)
      RADIX_HEX: ;
      RADIX_BIN: ok = ok && (d <= 4'd1);
      default:   ok = ok && (d <= 4'd9);
    endcase
    return {ok, d};
  endfunction

endpackage

// ----- sv/nll_step.sv -----
// Per-character state update and result formation of the literal lexer.
module nll_step
  import nll_pkg::*;
(
  input  nll_state_t  st,
  input  logic [7:0]  char_code,
  input  logic        last_char,
  output nll_state_t  st_nxt,
  output nll_result_t res
);

  logic [7:0]  lc;
  logic [4:0]  dig;
  logic        has_sfx;
  logic [67:0] prod;
  logic [67:0] sum;
  err_t        e;
  kind_t       k;
  nll_state_t  s;

  always_comb begin
    s       = st;
    lc      = to_lower(char_code);
    dig     = digit_of(char_code, st.radix);
    has_sfx = 1'b0;
    case (st.radix)
      RADIX_HEX: prod = {st.acc, 4'b0};
      RADIX_BIN: prod = {3'b0, st.acc, 1'b0};
      default:   prod = {1'b0, st.acc, 3'b0} + {3'b0, st.acc, 1'b0};
    endcase
    sum = prod + {64'b0, dig[3:0]};

    if (st.err == ERR_OK) begin
      if (st.pos == 2'd0 && char_code == CH_ZERO && !last_char) begin
        s.first_zero = 1'b1;
      end else if (st.pos == 2'd1 && st.first_zero && !last_char) begin
        if (lc == CH_X) s.radix = RADIX_HEX;
        else if (lc == CH_B) s.radix = RADIX_BIN;
        else s.err = ERR_BAD_PREFIX;
      end else begin
        // held-back leading zero counts as a digit; accumulator stays zero
        if (st.pos == 2'd1 && st.first_zero) s.digit_seen = 1'b1;
        if (char_code == CH_UNDER) begin
        end else if (char_code == CH_DOT) begin
          if (st.dot_seen || st.radix != RADIX_DEC) s.err = ERR_BAD_LIT;
          else s.dot_seen = 1'b1;
        end else if (dig[4]) begin
          s.acc        = sum[63:0];
          s.digit_seen = 1'b1;
          if (sum[67:64] != 4'd0) s.ovf_seen = 1'b1;
        end else if (!last_char) begin
          s.err = ERR_BAD_LIT;
        end else begin
          has_sfx = 1'b1;
        end
      end
    end
    if (st.pos != 2'd2) s.pos = st.pos + 2'd1;

    e = s.err;
    k = KIND_INT;
    if (e == ERR_OK) begin
      if (s.dot_seen) begin
        if (!has_sfx) k = KIND_DOUBLE;
        else if (lc == CH_F) k = KIND_FLOAT;
        else e = ERR_BAD_SUFFIX;
      end else begin
        if (!has_sfx) k = KIND_INT;
        else if (lc == CH_Y) k = KIND_BYTE;
        else if (lc == CH_S) k = KIND_SHORT;
        else if (lc == CH_L) k = KIND_LONG;
        else e = ERR_BAD_SUFFIX;
      end
    end
    if (e == ERR_OK && !s.digit_seen) e = ERR_NO_DIGITS;
    if (e == ERR_OK && s.ovf_seen && !s.dot_seen) e = ERR_RANGE;

    res.err = e;
    if (e != ERR_OK) begin
      res.kind  = KIND_INT;
      res.value = '0;
    end else begin
      res.kind = k;
      case (k)
        KIND_INT:   res.value = s.acc & MASK_INT;
        KIND_BYTE:  res.value = s.acc & MASK_BYTE;
        KIND_SHORT: res.value = s.acc & MASK_SHORT;
        KIND_LONG:  res.value = s.acc;
        default:    res.value = '0;
      endcase
    end

    // token done: return to reset state
    st_nxt = last_char ? STATE_RST : s;
  end

endmodule

// ----- sv/numeric_literal_lexer_core.sv -----
// Top level of the numeric literal lexer: input register, token state, result register.
//
//  channel | dir | handshake                  | payload
//  in_     | in  | in_tvalid / in_tready      | in_tdata[7:0] char_code, in_tlast last_char
//  out_    | out | out_tvalid / out_tready    | out_tdata kind, value, error code
//
// One character per cycle while no last character is stalled; a word waits in the input
// register and is folded into the token state as it leaves it, and a last character's
// result is written into the result register at that time. The token state (one
// shift-add of the accumulator) sets the rate. Reset is synchronous, active low, and
// clears all control state. A last character waits in the input register while the
// result register is full and stalled; other characters keep flowing.
module numeric_literal_lexer_core
  import nll_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // last_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // [2:0] literal_kind, [66:3] literal_value,
                                  // [69:67] error_code, [71:70] zero
);

  logic        s1_valid_r;
  logic [7:0]  s1_char_r;
  logic        s1_last_r;
  nll_state_t  st_r;
  nll_state_t  st_nxt;
  nll_result_t res;
  nll_result_t out_r;
  logic        out_valid_r;
  logic        s1_fire;

  nll_step u_step (
    .st        (st_r),
    .char_code (s1_char_r),
    .last_char (s1_last_r),
    .st_nxt    (st_nxt),
    .res       (res)
  );

  // a last word may only advance when the result register can take it
  assign s1_fire   = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= STATE_RST;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (s1_fire) st_r <= st_nxt;
      if (s1_fire && s1_last_r) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_char_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (s1_fire && s1_last_r) out_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_r.err, out_r.value, out_r.kind};

`ifndef SYNTH
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.err != ERR_OK) |-> (out_r.kind == KIND_INT && out_r.value == '0))
    else $error("error result carries nonzero kind or value");

  a_float_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.kind == KIND_FLOAT || out_r.kind == KIND_DOUBLE))
      |-> (out_r.value == '0))
    else $error("float literal with nonzero value");

  a_byte_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == KIND_BYTE) |-> (out_r.value[63:8] == '0))
    else $error("byte literal not masked");

  a_state_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> (st_r.pos == 2'd0 && st_r.err == ERR_OK && st_r.acc == '0))
    else $error("token state not cleared after result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_r)))
    else $error("pending result overwritten");
`endif

endmodule
